>>> hdl/rhd_pkg.sv
package rhd_pkg;

  localparam int unsigned PosW = 17;
  localparam int unsigned LenW = 16;

  localparam logic [PosW-1:0] POS_CHANNEL = 17'd1;
  localparam logic [PosW-1:0] POS_LEN_HI  = 17'd2;
  localparam logic [PosW-1:0] POS_LEN_LO  = 17'd3;
  localparam logic [PosW-1:0] POS_RTP0    = 17'd4;
  localparam logic [PosW-1:0] POS_NAL     = 17'd16;
  localparam logic [PosW-1:0] POS_FU      = 17'd17;
  localparam logic [PosW-1:0] POS_LIMIT   = 17'h1FFFF;
  localparam logic [PosW-1:0] LEN_HDR     = 17'd3;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_LENGTH    = 3'd1;
  localparam logic [2:0] STATUS_CHANNEL   = 3'd2;
  localparam logic [2:0] STATUS_AGGREGATE = 3'd3;
  localparam logic [2:0] STATUS_RESERVED  = 3'd4;
  localparam logic [2:0] STATUS_PAD_LONG  = 3'd5;

  localparam logic [4:0] NAL_SINGLE_LO = 5'd1;
  localparam logic [4:0] NAL_SINGLE_HI = 5'd23;
  localparam logic [4:0] NAL_AGG_LO    = 5'd24;
  localparam logic [4:0] NAL_AGG_HI    = 5'd27;
  localparam logic [4:0] NAL_FU_A      = 5'd28;
  localparam logic [4:0] NAL_FU_B      = 5'd29;

  localparam logic [1:0] SC_LAST = 2'd3;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SINGLE,
    KIND_FU,
    KIND_DROP
  } pkt_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SC,
    ST_FLUSH,
    ST_TAIL
  } ctrl_state_e;

  typedef enum logic [2:0] {
    SEL_NOW_CV,
    SEL_NOW_MARK,
    SEL_SC,
    SEL_BUF,
    SEL_CV
  } out_sel_e;

  typedef struct packed {
    logic     accept;
    logic     load;
    out_sel_e sel;
    logic [1:0] sc_idx;
    logic     packet_end;
    logic     flush_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic plan_sc;
    logic plan_flush;
    logic plan_tail;
    logic plan_marker;
    logic plan_last;
    logic flush_nz;
    logic flush_one;
    logic tail_q;
    logic last_q;
  } dp_status_t;

endpackage

>>> hdl/rhd_in_if.sv
interface rhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       frame_last;

  modport source (output valid, stream_byte, frame_last, input ready);
  modport sink (input valid, stream_byte, frame_last, output ready);
endinterface

>>> hdl/rhd_out_if.sv
interface rhd_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] out_byte;
  logic       unit_start;
  logic       packet_end;
  logic [2:0] status;

  modport source (output valid, data_valid, out_byte, unit_start, packet_end, status,
                  input ready);
  modport sink (input valid, data_valid, out_byte, unit_start, packet_end, status,
                output ready);
endinterface

>>> hdl/rhd_ctrl.sv
module rhd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rhd_pkg::dp_status_t stat_i,
  output rhd_pkg::ctrl_cmd_t  cmd_o
);

  rhd_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]           sc_q, sc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhd_pkg::ST_IDLE;
      sc_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      sc_q    <= sc_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sc_d       = sc_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = rhd_pkg::SEL_CV;
    case (state_q)
      rhd_pkg::ST_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (stat_i.plan_sc) begin
            state_d = rhd_pkg::ST_SC;
            sc_d    = 2'd0;
          end else if (stat_i.plan_flush) begin
            state_d = rhd_pkg::ST_FLUSH;
          end else if (stat_i.plan_tail) begin
            cmd_o.load       = 1'b1;
            cmd_o.sel        = rhd_pkg::SEL_NOW_CV;
            cmd_o.packet_end = stat_i.plan_last;
          end else if (stat_i.plan_marker) begin
            cmd_o.load       = 1'b1;
            cmd_o.sel        = rhd_pkg::SEL_NOW_MARK;
            cmd_o.packet_end = 1'b1;
          end
        end
      end
      rhd_pkg::ST_SC: begin
        if (stat_i.out_free) begin
          cmd_o.load   = 1'b1;
          cmd_o.sel    = rhd_pkg::SEL_SC;
          cmd_o.sc_idx = sc_q;
          sc_d         = sc_q + 2'd1;
          if (sc_q == rhd_pkg::SC_LAST) begin
            cmd_o.packet_end = stat_i.last_q && !stat_i.flush_nz && !stat_i.tail_q;
            if (stat_i.flush_nz) begin
              state_d = rhd_pkg::ST_FLUSH;
            end else if (stat_i.tail_q) begin
              state_d = rhd_pkg::ST_TAIL;
            end else begin
              state_d = rhd_pkg::ST_IDLE;
            end
          end
        end
      end
      rhd_pkg::ST_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.load       = 1'b1;
          cmd_o.sel        = rhd_pkg::SEL_BUF;
          cmd_o.flush_step = 1'b1;
          if (stat_i.flush_one) begin
            cmd_o.packet_end = stat_i.last_q && !stat_i.tail_q;
            state_d = stat_i.tail_q ? rhd_pkg::ST_TAIL : rhd_pkg::ST_IDLE;
          end
        end
      end
      rhd_pkg::ST_TAIL: begin
        if (stat_i.out_free) begin
          cmd_o.load       = 1'b1;
          cmd_o.sel        = rhd_pkg::SEL_CV;
          cmd_o.packet_end = stat_i.last_q;
          state_d          = rhd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rhd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/rhd_dpath.sv
module rhd_dpath #(
  parameter int unsigned MAX_PAD = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                out_ready_i,
  input  rhd_pkg::ctrl_cmd_t  cmd_i,
  output rhd_pkg::dp_status_t stat_o,
  output logic                out_valid_o,
  output logic                data_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                unit_start_o,
  output logic                packet_end_o,
  output logic [2:0]          out_status_o
);

  localparam int unsigned CW = $clog2(MAX_PAD + 1);
  localparam int unsigned PW = (MAX_PAD > 1) ? $clog2(MAX_PAD) : 1;
  localparam int unsigned AW = CW + 1;
  localparam int unsigned KW = 9;
  localparam logic [PW-1:0] PTR_TOP = PW'(MAX_PAD - 1);

  // frame state
  logic [7:0]                chan_q;
  logic [rhd_pkg::PosW-1:0]  pos_q;
  logic [rhd_pkg::LenW-1:0]  len_q;
  logic                      pad_q;
  rhd_pkg::pkt_kind_e        kind_q;
  logic [2:0]                nri_q;
  logic [2:0]                fe_q;
  logic [PW-1:0]             head_q;
  logic [CW-1:0]             count_q;

  // per-transaction plan
  logic [7:0]                cv_q;
  logic [2:0]                err_q;
  logic                      last_q;
  logic                      tail_q;
  logic [CW-1:0]             flush_left_q;
  logic [PW-1:0]             flush_ptr_q;

  // hold memory
  logic [7:0]                mem [MAX_PAD];
  logic [7:0]                rd_data_q;
  logic [PW-1:0]             rd_addr;
  logic [PW-1:0]             wr_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_sum;

  // output register
  logic                      out_valid_q;
  logic                      data_valid_q;
  logic [7:0]                out_byte_q;
  logic                      unit_start_q;
  logic                      packet_end_q;
  logic [2:0]                status_q;
  logic                      data_valid_d;
  logic [7:0]                out_byte_d;
  logic                      unit_start_d;
  logic [2:0]                status_d;

  // decode
  logic [rhd_pkg::LenW-1:0]  len_d;
  logic                      pad_d;
  rhd_pkg::pkt_kind_e        kind_d;
  logic [2:0]                nri_d;
  logic [2:0]                fe1;
  logic [2:0]                fe2;
  logic [2:0]                err_d;
  logic                      sc_d;
  logic                      cand;
  logic [7:0]                cv_d;
  logic [4:0]                nal_t;
  logic                      full;
  logic [KW-1:0]             total;
  logic [KW-1:0]             keep;
  logic [CW-1:0]             nflush;
  logic                      tail_d;
  logic [rhd_pkg::PosW-1:0]  len_end;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_TOP) ? '0 : p + 1'b1;
  endfunction

  assign nal_t = in_byte_i[4:0];
  assign full  = (count_q >= CW'(MAX_PAD));

  always_comb begin
    fe1    = fe_q;
    len_d  = len_q;
    pad_d  = pad_q;
    kind_d = kind_q;
    nri_d  = nri_q;
    sc_d   = 1'b0;
    cand   = 1'b0;
    cv_d   = in_byte_i;

    if (fe_q == rhd_pkg::STATUS_OK) begin
      if (pos_q >= rhd_pkg::POS_RTP0 && pos_q > ({1'b0, len_q} + rhd_pkg::LEN_HDR)) begin
        fe1 = rhd_pkg::STATUS_LENGTH;
      end else if (pos_q == rhd_pkg::POS_CHANNEL && in_byte_i != chan_q) begin
        fe1 = rhd_pkg::STATUS_CHANNEL;
      end
    end
    if (pos_q == rhd_pkg::POS_LEN_HI) begin
      len_d = {in_byte_i, 8'h00};
    end else if (pos_q == rhd_pkg::POS_LEN_LO) begin
      len_d = {len_q[15:8], in_byte_i};
    end else if (pos_q == rhd_pkg::POS_RTP0) begin
      pad_d = in_byte_i[5];
    end

    fe2 = fe1;
    if (fe1 == rhd_pkg::STATUS_OK) begin
      if (pos_q == rhd_pkg::POS_NAL) begin
        if (nal_t inside {[rhd_pkg::NAL_SINGLE_LO:rhd_pkg::NAL_SINGLE_HI]}) begin
          kind_d = rhd_pkg::KIND_SINGLE;
          sc_d   = 1'b1;
          cand   = 1'b1;
        end else if (nal_t == rhd_pkg::NAL_FU_A || nal_t == rhd_pkg::NAL_FU_B) begin
          kind_d = rhd_pkg::KIND_FU;
          nri_d  = in_byte_i[7:5];
        end else begin
          kind_d = rhd_pkg::KIND_DROP;
          fe2    = (nal_t inside {[rhd_pkg::NAL_AGG_LO:rhd_pkg::NAL_AGG_HI]}) ?
                   rhd_pkg::STATUS_AGGREGATE : rhd_pkg::STATUS_RESERVED;
        end
      end else if (pos_q == rhd_pkg::POS_FU && kind_q == rhd_pkg::KIND_FU) begin
        if (in_byte_i[7]) begin
          sc_d = 1'b1;
          cand = 1'b1;
          cv_d = {nri_q, in_byte_i[4:0]};
        end
      end else if (pos_q >= rhd_pkg::POS_FU &&
                   (kind_q == rhd_pkg::KIND_SINGLE || kind_q == rhd_pkg::KIND_FU)) begin
        cand = 1'b1;
      end
    end
  end

  assign len_end = {1'b0, len_d} + rhd_pkg::LEN_HDR;

  always_comb begin
    err_d  = fe2;
    total  = KW'(count_q) + KW'(cand);
    keep   = '0;
    nflush = '0;
    tail_d = 1'b0;
    if (in_last_i) begin
      if (fe2 == rhd_pkg::STATUS_OK &&
          (pos_q < rhd_pkg::POS_LEN_LO || pos_q != len_end)) begin
        err_d = rhd_pkg::STATUS_LENGTH;
      end
      if (err_d == rhd_pkg::STATUS_OK) begin
        if (!pad_d) begin
          tail_d = cand;
        end else begin
          if (KW'(in_byte_i) > total) begin
            err_d = rhd_pkg::STATUS_PAD_LONG;
            keep  = '0;
          end else begin
            keep = total - KW'(in_byte_i);
          end
          nflush = (keep < KW'(count_q)) ? CW'(keep) : count_q;
          tail_d = (keep > KW'(count_q));
        end
      end
    end else if (cand) begin
      if (!pad_d) begin
        tail_d = 1'b1;
      end else if (full) begin
        nflush = CW'(1);
      end
    end
  end

  // hold memory write and read
  assign wr_sum  = AW'(head_q) + AW'(count_q);
  assign wr_addr = full ? head_q :
                   ((wr_sum >= AW'(MAX_PAD)) ? PW'(wr_sum - AW'(MAX_PAD)) : PW'(wr_sum));
  assign wr_en   = cmd_i.accept && !in_last_i && cand && pad_d;
  assign rd_addr = cmd_i.accept ? head_q : flush_ptr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cv_d;
    end
    if (cmd_i.accept || cmd_i.flush_step) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= 8'd0;
      pos_q   <= '0;
      len_q   <= '0;
      pad_q   <= 1'b0;
      kind_q  <= rhd_pkg::KIND_NONE;
      nri_q   <= 3'd0;
      fe_q    <= rhd_pkg::STATUS_OK;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        chan_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        if (in_last_i) begin
          pos_q   <= '0;
          len_q   <= '0;
          pad_q   <= 1'b0;
          kind_q  <= rhd_pkg::KIND_NONE;
          nri_q   <= 3'd0;
          fe_q    <= rhd_pkg::STATUS_OK;
          head_q  <= '0;
          count_q <= '0;
        end else begin
          pos_q  <= (pos_q < rhd_pkg::POS_LIMIT) ? pos_q + 17'd1 : rhd_pkg::POS_LIMIT;
          len_q  <= len_d;
          pad_q  <= pad_d;
          kind_q <= kind_d;
          nri_q  <= nri_d;
          fe_q   <= fe2;
          if (cand && pad_d) begin
            if (full) begin
              head_q <= ptr_inc(head_q);
            end else begin
              count_q <= count_q + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= 1'b0;
      tail_q       <= 1'b0;
      flush_left_q <= '0;
      flush_ptr_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        last_q       <= in_last_i;
        tail_q       <= tail_d;
        flush_left_q <= nflush;
        flush_ptr_q  <= ptr_inc(head_q);
      end else if (cmd_i.flush_step) begin
        flush_left_q <= flush_left_q - 1'b1;
        flush_ptr_q  <= ptr_inc(flush_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cv_q  <= cv_d;
      err_q <= err_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    data_valid_d = 1'b1;
    out_byte_d   = cv_q;
    unit_start_d = 1'b0;
    status_d     = err_q;
    case (cmd_i.sel)
      rhd_pkg::SEL_NOW_CV: begin
        out_byte_d = cv_d;
        status_d   = err_d;
      end
      rhd_pkg::SEL_NOW_MARK: begin
        data_valid_d = 1'b0;
        out_byte_d   = 8'd0;
        status_d     = err_d;
      end
      rhd_pkg::SEL_SC: begin
        out_byte_d   = (cmd_i.sc_idx == rhd_pkg::SC_LAST) ? 8'd1 : 8'd0;
        unit_start_d = (cmd_i.sc_idx == 2'd0);
      end
      rhd_pkg::SEL_BUF: begin
        out_byte_d = rd_data_q;
      end
      default: begin
        out_byte_d = cv_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      packet_end_q <= cmd_i.packet_end;
      unit_start_q <= unit_start_d;
      data_valid_q <= data_valid_d;
      status_q     <= status_d;
      out_byte_q   <= out_byte_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_valid_o = data_valid_q;
  assign out_byte_o   = out_byte_q;
  assign unit_start_o = unit_start_q;
  assign packet_end_o = packet_end_q;
  assign out_status_o = status_q;

  always_comb begin
    stat_o             = '0;
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.plan_sc     = sc_d;
    stat_o.plan_flush  = (nflush != '0);
    stat_o.plan_tail   = tail_d;
    stat_o.plan_marker = in_last_i && !sc_d && (nflush == '0) && !tail_d;
    stat_o.plan_last   = in_last_i;
    stat_o.flush_nz    = (flush_left_q != '0);
    stat_o.flush_one   = (flush_left_q == CW'(1));
    stat_o.tail_q      = tail_q;
    stat_o.last_q      = last_q;
  end

endmodule

>>> hdl/rtp_h264_depacketizer.sv
// channel   dir  handshake        payload
// in_ch     in   valid / ready    stream_byte[7:0], frame_last
// out_ch    out  valid / ready    data_valid, out_byte[7:0], unit_start, packet_end,
//                                 status[2:0]
// cfg       in   cfg_we_i         cfg_data_i[7:0] (expected channel)
//
// a byte with no result or one direct result is handled in ST_IDLE as it is accepted, frame ends included
// a start code is accepted, then sent from ST_SC as 00 00 00 01, then the header byte from ST_TAIL if not held
// a byte that pushes out the oldest held byte is accepted, then the oldest byte is read out in ST_FLUSH
// a padded frame end is accepted, then held bytes go out one per cycle while out_ch is free,
// through the one read port, then the last byte if kept; rst_ni clears control state at once
// a stalled output holds in_ch.ready low until the pending result is taken
module rtp_h264_depacketizer #(
  parameter int unsigned MAX_PAD = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  rhd_in_if.sink      in_ch,
  rhd_out_if.source   out_ch
);

  rhd_pkg::ctrl_cmd_t  cmd;
  rhd_pkg::dp_status_t stat;

  rhd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rhd_dpath #(
    .MAX_PAD (MAX_PAD)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (in_ch.stream_byte),
    .in_last_i    (in_ch.frame_last),
    .out_ready_i  (out_ch.ready),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_ch.valid),
    .data_valid_o (out_ch.data_valid),
    .out_byte_o   (out_ch.out_byte),
    .unit_start_o (out_ch.unit_start),
    .packet_end_o (out_ch.packet_end),
    .out_status_o (out_ch.status)
  );

endmodule

>>> hdl/rhd_checker.sv
module rhd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       data_valid_i,
  input logic [7:0] out_byte_i,
  input logic       unit_start_i,
  input logic       packet_end_i,
  input logic [2:0] status_i
);

  // status codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= rhd_pkg::STATUS_PAD_LONG)
    else $error("status code out of range");

  // a transaction without data is the end-of-frame marker with a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !data_valid_i) |-> (packet_end_i && out_byte_i == 8'd0))
    else $error("marker transaction malformed");

  // a unit start is the first zero byte of a start code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && unit_start_i) |-> (data_valid_i && out_byte_i == 8'd0))
    else $error("unit start not on a start code byte");

  // a stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_byte_i) && $stable(packet_end_i) && $stable(status_i)))
    else $error("stalled output changed");

endmodule

bind rtp_h264_depacketizer rhd_checker u_rhd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .data_valid_i (out_ch.data_valid),
  .out_byte_i   (out_ch.out_byte),
  .unit_start_i (out_ch.unit_start),
  .packet_end_i (out_ch.packet_end),
  .status_i     (out_ch.status)
);
